// File: design/tsr_pkg.sv
// ----------------------------------------------------------------------------
// tsr_pkg
// shared types and constants of the trapezoid span rasterizer
// ----------------------------------------------------------------------------
package tsr_pkg;

  // configuration register file
  localparam int CFG_W     = 13;
  localparam int CFG_IDX_W = 1;

  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT = 1'b1;

  localparam logic [CFG_W-1:0] FRAME_WIDTH_RST  = 13'd1024;
  localparam logic [CFG_W-1:0] FRAME_HEIGHT_RST = 13'd768;

  // result field widths
  localparam int FIRST_X_W = 12;
  localparam int COUNT_W   = 13;

  // item kinds
  localparam logic KIND_LOAD    = 1'b0;
  localparam logic KIND_REQUEST = 1'b1;

  // controller states, one-hot
  typedef enum logic [2:0] {
    ST_IDLE  = 3'b001,
    ST_SETUP = 3'b010,
    ST_WALK  = 3'b100
  } tsr_state_e;

  // controller to datapath
  typedef struct packed {
    logic load;      // load transfer taken
    logic req;       // span request transfer taken
    logic setup;     // initialise bresenham error terms
    logic walk;      // one edge walk iteration
    logic walk_end;  // write back error terms
  } tsr_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic active;    // trapezoid in progress
    logic at_final;  // current row is the last row
    logic busy;      // an edge can still step this row
  } tsr_status_t;

endpackage

// File: design/tsr_ctrl.sv
// ----------------------------------------------------------------------------
// tsr_ctrl
// sequencer of the span rasterizer: input/output handshakes and edge walk
// ----------------------------------------------------------------------------
module tsr_ctrl import tsr_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic        kind_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  input  tsr_status_t status_i,
  output tsr_cmd_t    cmd_o
);

  tsr_state_e state_q, state_d;
  logic       out_valid_q, out_valid_d;
  logic       in_take;

  // an input transfer needs the block idle and the output register free or draining
  assign in_stall_o = (state_q != ST_IDLE) || (out_valid_q && out_stall_i);
  assign in_take    = in_valid_i && !in_stall_o;

  always_comb begin
    cmd_o          = '0;
    cmd_o.load     = in_take && (kind_i == KIND_LOAD);
    cmd_o.req      = in_take && (kind_i == KIND_REQUEST);
    cmd_o.setup    = (state_q == ST_SETUP);
    cmd_o.walk     = (state_q == ST_WALK);
    cmd_o.walk_end = (state_q == ST_WALK) && !status_i.busy;
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (cmd_o.load) begin
          state_d = ST_SETUP;
        end else if (cmd_o.req && status_i.active && !status_i.at_final) begin
          state_d = ST_WALK;
        end
      end
      ST_SETUP: begin
        state_d = ST_IDLE;
      end
      ST_WALK: begin
        if (!status_i.busy) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  assign out_valid_d = cmd_o.req || (out_valid_q && out_stall_i);
  assign out_valid_o = out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

// File: design/tsr_dp.sv
// ----------------------------------------------------------------------------
// tsr_dp
// datapath: frame registers, edge state, span clipping and edge stepping
// ----------------------------------------------------------------------------
module tsr_dp import tsr_pkg::*; #(
  parameter int COORD_BITS = 16,
  parameter int MAX_FRAME  = 4096
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [CFG_IDX_W-1:0]         cfg_idx_i,
  input  logic [CFG_W-1:0]             cfg_wdata_i,
  input  tsr_cmd_t                     cmd_i,
  output tsr_status_t                  status_o,
  input  logic signed [COORD_BITS-1:0] bottom_row_i,
  input  logic signed [COORD_BITS-1:0] top_row_i,
  input  logic signed [COORD_BITS-1:0] left_start_x_i,
  input  logic signed [COORD_BITS-1:0] left_end_x_i,
  input  logic signed [COORD_BITS-1:0] right_start_x_i,
  input  logic signed [COORD_BITS-1:0] right_end_x_i,
  output logic                         row_active_o,
  output logic signed [COORD_BITS-1:0] row_y_o,
  output logic                         span_visible_o,
  output logic [FIRST_X_W-1:0]         span_first_x_o,
  output logic [COUNT_W-1:0]           span_count_o,
  output logic                         last_row_o
);

  localparam int CW    = COORD_BITS;
  localparam int DW    = CW + 1;   // delta and row span
  localparam int EW    = CW + 2;   // stored error term
  localparam int AW    = CW + 3;   // error term during the walk
  localparam int CMP_W = ((CW > CFG_W) ? CW : CFG_W) + 2;

  localparam logic [CFG_W-1:0]        MAX_FRAME_C = CFG_W'(MAX_FRAME);
  localparam logic signed [CMP_W-1:0] ONE_S       = CMP_W'(1);

  // frame configuration
  logic [CFG_W-1:0] frame_width_q, frame_height_q;
  logic [CFG_W-1:0] fw, fh;

  // trapezoid state
  logic                 active_q;
  logic signed [CW-1:0] row_q, final_q;
  logic signed [CW-1:0] lx_q, ltgt_q, rx_q, rtgt_q;
  logic signed [EW-1:0] lerr_q, rerr_q;
  logic signed [AW-1:0] lacc_q, racc_q;
  logic [DW-1:0]        ldelta_q, rdelta_q, span_q;
  logic                 lneg_q, rneg_q;

  // output register
  logic                 row_active_q, span_visible_q, last_row_q;
  logic signed [CW-1:0] row_y_q;
  logic [FIRST_X_W-1:0] span_first_x_q;
  logic [COUNT_W-1:0]   span_count_q;

  // load decode
  logic signed [CMP_W-1:0] yl_ext, fh_ext, fw_ext;
  logic                    load_ok;
  logic signed [DW-1:0]    span_diff, ldiff, rdiff;
  logic                    lneg_d, rneg_d;
  logic [DW-1:0]           ldelta_d, rdelta_d;
  logic [EW-1:0]           lhalf, rhalf;

  // span clipping
  logic                    row_in;
  logic signed [CMP_W-1:0] first_ext, end_raw, end_clip, count_ext;
  logic                    visible;
  logic                    at_final;

  // walk
  logic l_busy, r_busy;

  assign fw = (int'(frame_width_q) > MAX_FRAME) ? MAX_FRAME_C : frame_width_q;
  assign fh = (int'(frame_height_q) > MAX_FRAME) ? MAX_FRAME_C : frame_height_q;

  assign fw_ext = $signed({{(CMP_W-CFG_W){1'b0}}, fw});
  assign fh_ext = $signed({{(CMP_W-CFG_W){1'b0}}, fh});
  assign yl_ext = CMP_W'(bottom_row_i);

  assign load_ok = !(yl_ext >= fh_ext) && !top_row_i[CW-1] && !(top_row_i < bottom_row_i);

  assign span_diff = DW'(top_row_i) - DW'(bottom_row_i);
  assign lneg_d    = left_end_x_i < left_start_x_i;
  assign rneg_d    = right_end_x_i < right_start_x_i;
  assign ldiff     = DW'(left_end_x_i) - DW'(left_start_x_i);
  assign rdiff     = DW'(right_end_x_i) - DW'(right_start_x_i);
  assign ldelta_d  = lneg_d ? DW'(-ldiff) : DW'(ldiff);
  assign rdelta_d  = rneg_d ? DW'(-rdiff) : DW'(rdiff);

  // rounded half of the delta, negated later
  assign lhalf = ({1'b0, ldelta_q} + EW'(1)) >> 1;
  assign rhalf = ({1'b0, rdelta_q} + EW'(1)) >> 1;

  assign row_in    = !row_q[CW-1] && (CMP_W'(row_q) < fh_ext);
  assign first_ext = lx_q[CW-1] ? '0 : CMP_W'(lx_q);
  assign end_raw   = CMP_W'(rx_q) + ONE_S;
  assign end_clip  = (end_raw > fw_ext) ? fw_ext : end_raw;
  assign visible   = row_in && (end_clip > first_ext);
  assign count_ext = end_clip - first_ext;
  assign at_final  = (row_q == final_q);

  assign l_busy = (lacc_q > 0) && (lx_q != ltgt_q);
  assign r_busy = (racc_q > 0) && (rx_q != rtgt_q);

  always_comb begin
    status_o          = '0;
    status_o.active   = active_q;
    status_o.at_final = at_final;
    status_o.busy     = l_busy || r_busy;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_width_q  <= FRAME_WIDTH_RST;
      frame_height_q <= FRAME_HEIGHT_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_FRAME_WIDTH:  frame_width_q  <= cfg_wdata_i;
        CFG_FRAME_HEIGHT: frame_height_q <= cfg_wdata_i;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= 1'b0;
      row_q    <= '0;
      final_q  <= '0;
      lx_q     <= '0;
      ltgt_q   <= '0;
      rx_q     <= '0;
      rtgt_q   <= '0;
      lerr_q   <= '0;
      rerr_q   <= '0;
      lacc_q   <= '0;
      racc_q   <= '0;
      ldelta_q <= '0;
      rdelta_q <= '0;
      span_q   <= '0;
      lneg_q   <= 1'b0;
      rneg_q   <= 1'b0;
    end else begin
      if (cmd_i.load) begin
        active_q <= load_ok;
        if (load_ok) begin
          row_q    <= bottom_row_i;
          final_q  <= top_row_i;
          span_q   <= DW'(span_diff);
          lx_q     <= left_start_x_i;
          ltgt_q   <= left_end_x_i;
          rx_q     <= right_start_x_i;
          rtgt_q   <= right_end_x_i;
          lneg_q   <= lneg_d;
          rneg_q   <= rneg_d;
          ldelta_q <= ldelta_d;
          rdelta_q <= rdelta_d;
        end
      end
      if (cmd_i.setup && active_q) begin
        lerr_q <= -lhalf;
        rerr_q <= -rhalf;
      end
      if (cmd_i.req && active_q) begin
        if (at_final) begin
          active_q <= 1'b0;
        end else begin
          row_q  <= row_q + CW'(1);
          lacc_q <= AW'(lerr_q) + $signed({2'b00, ldelta_q});
          racc_q <= AW'(rerr_q) + $signed({2'b00, rdelta_q});
        end
      end
      if (cmd_i.walk) begin
        if (l_busy) begin
          lacc_q <= lacc_q - $signed({2'b00, span_q});
          lx_q   <= lneg_q ? lx_q - CW'(1) : lx_q + CW'(1);
        end
        if (r_busy) begin
          racc_q <= racc_q - $signed({2'b00, span_q});
          rx_q   <= rneg_q ? rx_q - CW'(1) : rx_q + CW'(1);
        end
      end
      if (cmd_i.walk_end) begin
        lerr_q <= lacc_q[EW-1:0];
        rerr_q <= racc_q[EW-1:0];
      end
    end
  end

  // result register, loaded on every request
  always_ff @(posedge clk_i) begin
    if (cmd_i.req) begin
      row_active_q   <= active_q;
      row_y_q        <= active_q ? row_q : '0;
      span_visible_q <= active_q && visible;
      span_first_x_q <= (active_q && visible) ? first_ext[FIRST_X_W-1:0] : '0;
      span_count_q   <= (active_q && visible) ? count_ext[COUNT_W-1:0] : '0;
      last_row_q     <= active_q && at_final;
    end
  end

  assign row_active_o   = row_active_q;
  assign row_y_o        = row_y_q;
  assign span_visible_o = span_visible_q;
  assign span_first_x_o = span_first_x_q;
  assign span_count_o   = span_count_q;
  assign last_row_o     = last_row_q;

endmodule

// File: design/trapezoid_span_rasterizer_top.sv
// ----------------------------------------------------------------------------
// trapezoid_span_rasterizer_top
// bresenham trapezoid edge walker producing one clipped span per row
// ----------------------------------------------------------------------------
// A load transfer (kind 0) sets up a trapezoid: it first captures the rows,
// edge positions, step directions and deltas, and the setup state then forms
// the bresenham error terms; it gives no result. A request transfer
// (kind 1) gives one result: the current row's span clipped to the frame.
// If the trapezoid is inactive or the row is its last one the request needs
// no walk. Otherwise the edges are then walked for the next row, one error
// subtraction per edge per cycle with both edges stepping together, until
// neither edge can step further in that row; each edge takes its pixel steps
// for that row (steep edges: 0 or 1; shallow edges: up to the edge's x travel
// divided by the row count). The walk loop sets the rate.
// Results wait in an output register while the walk carries on; a further
// transfer is held off until setup or the walk ends and the output
// register is free. frame_width and frame_height, clamped to MAX_FRAME, must
// be written only while the block is idle; the block does not enforce this.
// ----------------------------------------------------------------------------
module trapezoid_span_rasterizer_top import tsr_pkg::*; #(
  parameter int COORD_BITS = 16,
  parameter int MAX_FRAME  = 4096
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  // configuration write port
  input  logic                         cfg_we_i,
  input  logic [CFG_IDX_W-1:0]         cfg_idx_i,
  input  logic [CFG_W-1:0]             cfg_wdata_i,
  // input channel
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic                         kind_i,
  input  logic signed [COORD_BITS-1:0] bottom_row_i,
  input  logic signed [COORD_BITS-1:0] top_row_i,
  input  logic signed [COORD_BITS-1:0] left_start_x_i,
  input  logic signed [COORD_BITS-1:0] left_end_x_i,
  input  logic signed [COORD_BITS-1:0] right_start_x_i,
  input  logic signed [COORD_BITS-1:0] right_end_x_i,
  // result channel
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic                         row_active_o,
  output logic signed [COORD_BITS-1:0] row_y_o,
  output logic                         span_visible_o,
  output logic [FIRST_X_W-1:0]         span_first_x_o,
  output logic [COUNT_W-1:0]           span_count_o,
  output logic                         last_row_o
);

  // command and status between sequencer and datapath
  tsr_cmd_t    cmd;
  tsr_status_t status;

  // sequencer: handshakes, setup step and the edge walk loop
  tsr_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .kind_i      (kind_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  // datapath: frame registers, edge registers, clipping, stepping
  tsr_dp #(
    .COORD_BITS (COORD_BITS),
    .MAX_FRAME  (MAX_FRAME)
  ) u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_idx_i       (cfg_idx_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .cmd_i           (cmd),
    .status_o        (status),
    .bottom_row_i    (bottom_row_i),
    .top_row_i       (top_row_i),
    .left_start_x_i  (left_start_x_i),
    .left_end_x_i    (left_end_x_i),
    .right_start_x_i (right_start_x_i),
    .right_end_x_i   (right_end_x_i),
    .row_active_o    (row_active_o),
    .row_y_o         (row_y_o),
    .span_visible_o  (span_visible_o),
    .span_first_x_o  (span_first_x_o),
    .span_count_o    (span_count_o),
    .last_row_o      (last_row_o)
  );

  // no transfer is taken while the edges are being walked
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.walk |-> !(in_valid_i && !in_stall_o))
    else $error("input transfer taken during edge walk");

  // every request transfer puts a result in the output register
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.req |=> out_valid_o)
    else $error("request transfer without result");

  // an inactive result carries no span and no last row mark
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !row_active_o) |-> (!span_visible_o && !last_row_o))
    else $error("inactive result with span or last row");

  // a visible span always covers at least one pixel
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && span_visible_o) |-> (span_count_o != '0))
    else $error("visible span with zero count");

endmodule

// File: tb/trapezoid_span_rasterizer_top_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// trapezoid_span_rasterizer_top_tb
// self-checking bench: trapezoid loads and span requests against a predictor
// ----------------------------------------------------------------------------
// Loads and row requests are driven through the valid/stall input channel
// with random gaps. The result channel is stalled at random. Every accepted
// input transfer is passed to a span predictor. The predictor keeps its own
// copy of the edge walker and of the frame size, and queues the span that
// each request should give. Each accepted result is checked field by field
// against the oldest queued span. The run steps through several frame sizes,
// the extremes among them, and writes them only while the block is idle.
// ----------------------------------------------------------------------------
module trapezoid_span_rasterizer_top_tb;
  import tsr_pkg::*;

  localparam int CW              = 16;
  localparam int MAX_FRAME       = 4096;
  localparam int ITEMS_PER_PHASE = 90;
  // longest correct silence: a full 65535-pixel edge walk plus both stalls
  localparam int QUIET_LIMIT     = 400000;

  typedef logic signed [CW-1:0] coord_t;

  typedef struct {
    logic   kind;
    coord_t bottom;
    coord_t top;
    coord_t left_from;
    coord_t left_to;
    coord_t right_from;
    coord_t right_to;
  } trap_item_t;

  typedef struct {
    logic                 active;
    coord_t               row;
    logic                 visible;
    logic [FIRST_X_W-1:0] first_x;
    logic [COUNT_W-1:0]   count;
    logic                 last;
  } span_t;

  // --------------------------------------------------------------------------
  // span predictor and checker
  // --------------------------------------------------------------------------
  class span_scoreboard;
    logic [CFG_W-1:0] frame_w;
    logic [CFG_W-1:0] frame_h;
    bit               live;
    longint           row_now;
    longint           row_stop;
    longint           walk_rows;
    longint           lx, lx_goal, ldelta, lerr;
    longint           rx, rx_goal, rdelta, rerr;
    bit               l_down, r_down;
    span_t            expected_spans[$];
    int               failures;

    function new();
      frame_w = FRAME_WIDTH_RST;
      frame_h = FRAME_HEIGHT_RST;
    endfunction

    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
      if (idx == CFG_FRAME_WIDTH) frame_w = val;
      else frame_h = val;
    endfunction

    function longint clamp_frame(logic [CFG_W-1:0] v);
      return (v > MAX_FRAME) ? MAX_FRAME : v;
    endfunction

    // one row of bresenham walk; the error term lives in 18 signed bits
    function void step_edge(inout longint x, inout longint err, input longint goal,
                            input longint delta, input bit down);
      longint             e;
      logic signed [17:0] wrapped;
      e = err + delta;
      while (e > 0 && x != goal) begin
        e -= walk_rows;
        x += down ? -1 : 1;
      end
      wrapped = e[17:0];
      err = wrapped;
    endfunction

    function void note_transfer(trap_item_t it);
      span_t  s;
      longint fw, fh, b, t, first, stop;
      fw = clamp_frame(frame_w);
      fh = clamp_frame(frame_h);
      if (it.kind == KIND_LOAD) begin
        b = it.bottom;
        t = it.top;
        // off the frame or upside down: nothing to draw
        if (b >= fh || t < 0 || t < b) begin
          live = 0;
          return;
        end
        live      = 1;
        row_now   = b;
        row_stop  = t;
        walk_rows = t - b;
        lx        = it.left_from;
        lx_goal   = it.left_to;
        rx        = it.right_from;
        rx_goal   = it.right_to;
        l_down    = lx_goal < lx;
        r_down    = rx_goal < rx;
        ldelta    = l_down ? lx - lx_goal : lx_goal - lx;
        rdelta    = r_down ? rx - rx_goal : rx_goal - rx;
        lerr      = -((ldelta + 1) / 2);
        rerr      = -((rdelta + 1) / 2);
        return;
      end
      s = '{default: '0};
      if (live) begin
        s.active = 1'b1;
        s.row    = row_now[CW-1:0];
        if (row_now >= 0 && row_now < fh) begin
          first = (lx >= 0) ? lx : 0;
          stop  = (rx + 1 > fw) ? fw : rx + 1;
          if (stop > first) begin
            s.visible = 1'b1;
            s.first_x = first[FIRST_X_W-1:0];
            stop -= first;
            s.count = stop[COUNT_W-1:0];
          end
        end
        if (row_now == row_stop) begin
          s.last = 1'b1;
          live   = 0;
        end else begin
          row_now++;
          step_edge(lx, lerr, lx_goal, ldelta, l_down);
          step_edge(rx, rerr, rx_goal, rdelta, r_down);
        end
      end
      expected_spans.push_back(s);
    endfunction

    function void check_span(span_t got);
      span_t want;
      string diff;
      if (expected_spans.size() == 0) begin
        failures++;
        if (failures <= 10)
          $display("%0t: span with none expected (row_y %0d)", $time, got.row);
        return;
      end
      want = expected_spans.pop_front();
      diff = "";
      if (got.active !== want.active)
        diff = {diff, $sformatf(" row_active %0d/%0d", want.active, got.active)};
      if (got.row !== want.row)
        diff = {diff, $sformatf(" row_y %0d/%0d", want.row, got.row)};
      if (got.visible !== want.visible)
        diff = {diff, $sformatf(" span_visible %0d/%0d", want.visible, got.visible)};
      if (got.first_x !== want.first_x)
        diff = {diff, $sformatf(" span_first_x %0d/%0d", want.first_x, got.first_x)};
      if (got.count !== want.count)
        diff = {diff, $sformatf(" span_count %0d/%0d", want.count, got.count)};
      if (got.last !== want.last)
        diff = {diff, $sformatf(" last_row %0d/%0d", want.last, got.last)};
      if (diff != "") begin
        failures++;
        if (failures <= 10)
          $display("%0t: span mismatch (expected/actual):%s", $time, diff);
      end
    endfunction
  endclass

  // --------------------------------------------------------------------------
  // clock, reset and block under test
  // --------------------------------------------------------------------------
  logic                 clk_i;
  logic                 rst_ni;
  logic                 cfg_we_i;
  logic [CFG_IDX_W-1:0] cfg_idx_i;
  logic [CFG_W-1:0]     cfg_wdata_i;
  logic                 in_valid_i;
  logic                 in_stall_o;
  logic                 kind_i;
  coord_t               bottom_row_i;
  coord_t               top_row_i;
  coord_t               left_start_x_i;
  coord_t               left_end_x_i;
  coord_t               right_start_x_i;
  coord_t               right_end_x_i;
  logic                 out_valid_o;
  logic                 out_stall_i;
  logic                 row_active_o;
  coord_t               row_y_o;
  logic                 span_visible_o;
  logic [FIRST_X_W-1:0] span_first_x_o;
  logic [COUNT_W-1:0]   span_count_o;
  logic                 last_row_o;

  span_scoreboard sb = new();

  // back-to-back stretches on each side, toggled now and then
  bit in_rush  = 1'b0;
  bit out_rush = 1'b0;

  wire in_fire  = in_valid_i && !in_stall_o;
  wire out_fire = out_valid_o && !out_stall_i;

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  trapezoid_span_rasterizer_top #(
    .COORD_BITS (CW),
    .MAX_FRAME  (MAX_FRAME)
  ) u_top (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_idx_i       (cfg_idx_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .kind_i          (kind_i),
    .bottom_row_i    (bottom_row_i),
    .top_row_i       (top_row_i),
    .left_start_x_i  (left_start_x_i),
    .left_end_x_i    (left_end_x_i),
    .right_start_x_i (right_start_x_i),
    .right_end_x_i   (right_end_x_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .row_active_o    (row_active_o),
    .row_y_o         (row_y_o),
    .span_visible_o  (span_visible_o),
    .span_first_x_o  (span_first_x_o),
    .span_count_o    (span_count_o),
    .last_row_o      (last_row_o)
  );

  // --------------------------------------------------------------------------
  // monitors: sampled at the rising edge, inputs before results
  // --------------------------------------------------------------------------
  always @(posedge clk_i) begin
    trap_item_t seen;
    span_t      got;
    if (rst_ni && in_fire) begin
      seen.kind       = kind_i;
      seen.bottom     = bottom_row_i;
      seen.top        = top_row_i;
      seen.left_from  = left_start_x_i;
      seen.left_to    = left_end_x_i;
      seen.right_from = right_start_x_i;
      seen.right_to   = right_end_x_i;
      sb.note_transfer(seen);
    end
    if (rst_ni && out_fire) begin
      got.active  = row_active_o;
      got.row     = row_y_o;
      got.visible = span_visible_o;
      got.first_x = span_first_x_o;
      got.count   = span_count_o;
      got.last    = last_row_o;
      sb.check_span(got);
    end
  end

  // result side: hold stall high at random before each result transfer
  initial begin : result_stall
    int hold;
    out_stall_i <= 1'b0;
    forever begin
      if ($urandom_range(0, 29) == 0) out_rush = !out_rush;
      hold = out_rush ? 0 : $urandom_range(0, 9);
      if (hold > 0) begin
        @(negedge clk_i);
        out_stall_i <= 1'b1;
        repeat (hold - 1) @(negedge clk_i);
        @(negedge clk_i);
        out_stall_i <= 1'b0;
      end
      do @(posedge clk_i); while (!out_fire);
    end
  end

  // ends the run when neither channel moves for too long
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk_i);
      if (in_fire || out_fire) quiet = 0;
      else quiet++;
    end
    $display("** trapezoid_span_rasterizer_top: FAILED **");
    $finish;
  end

  // --------------------------------------------------------------------------
  // stimulus helpers
  // --------------------------------------------------------------------------
  function automatic coord_t pick_in(input int lo, input int hi);
    int v;
    v = $urandom_range(0, hi - lo);
    v += lo;
    return v[CW-1:0];
  endfunction

  // every field random over its full width
  function automatic trap_item_t any_item(input logic kind);
    trap_item_t it;
    logic [31:0] r0, r1, r2;
    r0 = $urandom();
    r1 = $urandom();
    r2 = $urandom();
    it.kind       = kind;
    it.bottom     = r0[15:0];
    it.top        = r0[31:16];
    it.left_from  = r1[15:0];
    it.left_to    = r1[31:16];
    it.right_from = r2[15:0];
    it.right_to   = r2[31:16];
    return it;
  endfunction

  function automatic trap_item_t make_load(input int b, t, lf, lt, rf, rt);
    trap_item_t it;
    it.kind       = KIND_LOAD;
    it.bottom     = b[CW-1:0];
    it.top        = t[CW-1:0];
    it.left_from  = lf[CW-1:0];
    it.left_to    = lt[CW-1:0];
    it.right_from = rf[CW-1:0];
    it.right_to   = rt[CW-1:0];
    return it;
  endfunction

  // one input transfer; valid stays high straight into a gapless next item
  task automatic push_item(input trap_item_t it);
    int gap;
    if ($urandom_range(0, 29) == 0) in_rush = !in_rush;
    gap = in_rush ? 0 : $urandom_range(0, 9);
    repeat (gap) begin
      @(negedge clk_i);
      in_valid_i <= 1'b0;
    end
    @(negedge clk_i);
    kind_i          <= it.kind;
    bottom_row_i    <= it.bottom;
    top_row_i       <= it.top;
    left_start_x_i  <= it.left_from;
    left_end_x_i    <= it.left_to;
    right_start_x_i <= it.right_from;
    right_end_x_i   <= it.right_to;
    in_valid_i      <= 1'b1;
    do @(posedge clk_i); while (in_stall_o);
  endtask

  // an always-refused load then a request that needs no walk: once that request has
  // been taken and answered, no edge walk can still be running
  task automatic drain_block();
    trap_item_t it;
    it = make_load(1, 0, 0, 0, 0, 0);
    push_item(it);
    it.kind = KIND_REQUEST;
    push_item(it);
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (sb.expected_spans.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_frame(input logic [CFG_W-1:0] w, input logic [CFG_W-1:0] h);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= CFG_FRAME_WIDTH;
    cfg_wdata_i <= w;
    @(negedge clk_i);
    cfg_idx_i   <= CFG_FRAME_HEIGHT;
    cfg_wdata_i <= h;
    @(negedge clk_i);
    cfg_we_i    <= 1'b0;
    sb.set_reg(CFG_FRAME_WIDTH, w);
    sb.set_reg(CFG_FRAME_HEIGHT, h);
  endtask

  // mostly whole trapezoids walked to their last row; the rest overruns,
  // cut-short walks, full-range loads and loose items
  task automatic random_phase(input int quota);
    trap_item_t it;
    int sent, pick, rows, reqs, fw, fh, lo, hi;
    sent = 0;
    while (sent < quota) begin
      pick = $urandom_range(0, 19);
      fw   = int'(sb.clamp_frame(sb.frame_w));
      fh   = int'(sb.clamp_frame(sb.frame_h));
      if (pick < 14) begin
        rows = ($urandom_range(0, 9) == 0) ? $urandom_range(16, 60) : $urandom_range(0, 15);
        // now and then a wide trapezoid with shallow edges
        if ($urandom_range(0, 7) == 0) begin
          lo = -3000;
          hi = 7000;
        end else begin
          lo = -64;
          hi = fw + 64;
        end
        it.kind       = KIND_LOAD;
        it.bottom     = pick_in(-24, fh + 8);
        it.top        = CW'(it.bottom + rows);
        it.left_from  = pick_in(lo, hi);
        it.left_to    = ($urandom_range(0, 5) == 0) ? it.left_from : pick_in(lo, hi);
        it.right_from = pick_in(lo, hi);
        it.right_to   = ($urandom_range(0, 5) == 0) ? it.right_from : pick_in(lo, hi);
        push_item(it);
        sent++;
        reqs = rows + 1;
        if (pick == 12) reqs += $urandom_range(1, 3);
        else if (pick == 13) reqs = $urandom_range(0, rows);
        repeat (reqs) begin
          push_item(any_item(KIND_REQUEST));
          sent++;
        end
      end else if (pick < 17) begin
        push_item(any_item(KIND_LOAD));
        sent++;
        reqs = $urandom_range(1, 3);
        repeat (reqs) begin
          push_item(any_item(KIND_REQUEST));
          sent++;
        end
      end else begin
        push_item(any_item(1'($urandom_range(0, 1))));
        sent++;
      end
    end
  endtask

  // --------------------------------------------------------------------------
  // main sequence
  // --------------------------------------------------------------------------
  initial begin : stimulus
    logic [CFG_W-1:0] fw_set[6];
    logic [CFG_W-1:0] fh_set[6];
    rst_ni          <= 1'b0;
    cfg_we_i        <= 1'b0;
    cfg_idx_i       <= CFG_FRAME_WIDTH;
    cfg_wdata_i     <= '0;
    in_valid_i      <= 1'b0;
    kind_i          <= KIND_LOAD;
    bottom_row_i    <= '0;
    top_row_i       <= '0;
    left_start_x_i  <= '0;
    left_end_x_i    <= '0;
    right_start_x_i <= '0;
    right_end_x_i   <= '0;
    repeat (10) @(negedge clk_i);
    rst_ni <= 1'b1;

    // directed part, reset frame size
    push_item(any_item(KIND_REQUEST));                        // nothing loaded yet
    push_item(make_load(768, 800, 0, 0, 0, 0));               // bottom at frame height
    push_item(any_item(KIND_REQUEST));
    push_item(make_load(-5, -1, 0, 10, 0, 10));               // top row below zero
    push_item(any_item(KIND_REQUEST));
    push_item(make_load(10, 9, 0, 10, 0, 10));                // upside down
    push_item(any_item(KIND_REQUEST));
    // full coordinate range, edges crossing
    push_item(make_load(-32768, 32767, -32768, 32767, 32767, -32768));
    push_item(any_item(KIND_REQUEST));
    push_item(any_item(KIND_REQUEST));
    // single row, clipped both sides, then idle again
    push_item(make_load(5, 5, -10, -10, 2000, 2000));
    push_item(any_item(KIND_REQUEST));
    push_item(any_item(KIND_REQUEST));
    // vertical left edge, very shallow right edge over the top of the frame
    push_item(make_load(766, 767, 100, 100, 0, 32767));
    repeat (3) push_item(any_item(KIND_REQUEST));
    // rows starting below the frame, span empty on the first rows
    push_item(make_load(-2, 3, 50, 20, 40, 60));
    repeat (6) push_item(any_item(KIND_REQUEST));
    random_phase(ITEMS_PER_PHASE);
    drain_block();

    // frame sizes: full, smallest, zero, oversized, random, ordinary
    fw_set = '{MAX_FRAME, 1, 0, 13'h1FFF, 0, 640};
    fh_set = '{MAX_FRAME, 1, 0, 13'h1FFF, 0, 480};
    fw_set[4] = CFG_W'($urandom_range(0, 8191));
    fh_set[4] = CFG_W'($urandom_range(0, 8191));
    for (int p = 0; p < 6; p++) begin
      write_frame(fw_set[p], fh_set[p]);
      random_phase(ITEMS_PER_PHASE);
      drain_block();
    end

    repeat (8) @(posedge clk_i);
    if (sb.failures == 0 && sb.expected_spans.size() == 0)
      $display("** trapezoid_span_rasterizer_top: PASSED **");
    else
      $display("** trapezoid_span_rasterizer_top: FAILED **");
    $finish;
  end

endmodule

// File: filelist.f
design/tsr_pkg.sv
design/tsr_ctrl.sv
design/tsr_dp.sv
design/trapezoid_span_rasterizer_top.sv
tb/trapezoid_span_rasterizer_top_tb.sv
